>>> design/contact_impulse_resolver_defines.svh
// ----------------------------------------------------------------------------
// Contact impulse resolver assertion macros
// Shared property wrappers for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef CONTACT_IMPULSE_RESOLVER_DEFINES_SVH
`define CONTACT_IMPULSE_RESOLVER_DEFINES_SVH

// check a property while out of reset
`define CIR_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// check a property at every edge, reset included
`define CIR_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

>>> design/cir_pkg.sv
// ----------------------------------------------------------------------------
// Contact impulse resolver package
// Shared widths, pipeline payload types and arithmetic helpers.
// ----------------------------------------------------------------------------
package cir_pkg;

    localparam int VelW    = 16;
    localparam int MassW   = 16;
    localparam int BncW    = 9;
    localparam int NrmW    = 16;
    localparam int SumW    = MassW + 1;
    localparam int KW      = 42;
    localparam int DivW    = KW + MassW;
    localparam int DivSteps = KW;
    localparam int ProdW   = KW + NrmW;
    localparam int MagW    = ProdW + 1 - 36;
    localparam int RndShift = 36;
    localparam logic [BncW-1:0] BncMax = 9'd256;

    typedef struct packed {
        logic signed [VelW-1:0] vax;
        logic signed [VelW-1:0] vay;
        logic signed [VelW-1:0] vbx;
        logic signed [VelW-1:0] vby;
        logic [MassW-1:0]       ima;
        logic [MassW-1:0]       imb;
        logic [BncW-1:0]        ba;
        logic [BncW-1:0]        bb;
        logic signed [NrmW-1:0] nx;
        logic signed [NrmW-1:0] ny;
    } in_t;

    typedef struct packed {
        logic signed [VelW-1:0] vax;
        logic signed [VelW-1:0] vay;
        logic signed [VelW-1:0] vbx;
        logic signed [VelW-1:0] vby;
        logic signed [NrmW-1:0] nx;
        logic signed [NrmW-1:0] ny;
        logic [KW-1:0]          k;
        logic                   applied;
    } ctx_t;

    typedef struct packed {
        logic [SumW-1:0] rem;
        logic [KW-1:0]   dq;
    } div_t;

    typedef struct packed {
        logic signed [VelW-1:0] vax;
        logic signed [VelW-1:0] vay;
        logic signed [VelW-1:0] vbx;
        logic signed [VelW-1:0] vby;
        logic                   applied;
    } out_t;

    function automatic div_t div_step(input div_t cur, input logic [SumW-1:0] s);
        logic [SumW:0] t;
        div_t nxt;
        t = {cur.rem, cur.dq[KW-1]};
        if (t >= {1'b0, s}) begin
            nxt.rem = SumW'(t - {1'b0, s});
            nxt.dq  = {cur.dq[KW-2:0], 1'b1};
        end else begin
            nxt.rem = t[SumW-1:0];
            nxt.dq  = {cur.dq[KW-2:0], 1'b0};
        end
        return nxt;
    endfunction

    function automatic logic signed [VelW-1:0] sat16(input logic signed [MagW+1:0] v);
        logic signed [VelW-1:0] r;
        if (v > (MagW+2)'(32767)) begin
            r = 16'sh7fff;
        end else if (v < -(MagW+2)'(32768)) begin
            r = 16'sh8000;
        end else begin
            r = v[VelW-1:0];
        end
        return r;
    endfunction

endpackage

>>> design/cir_front.sv
// ----------------------------------------------------------------------------
// Contact impulse resolver front end
// Closing speed, restitution scaling and divider dividend, four stages.
// ----------------------------------------------------------------------------
module cir_front import cir_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        en,
    input  logic        in_valid,
    input  in_t         in_data,
    output logic        out_valid,
    output logic [DivW-1:0] out_dividend,
    output logic [SumW-1:0] out_divisor,
    output ctx_t        out_ctx
);

    logic [3:0] valid_reg;

    ctx_t                   ctx_a_reg, ctx_b_reg, ctx_c_reg, ctx_d_reg;
    logic signed [32:0]     px_reg, py_reg;
    logic [MassW-1:0]       ima_a_reg, imb_a_reg, ima_b_reg, ima_c_reg;
    logic [BncW-1:0]        e_a_reg, e_b_reg;
    logic [SumW-1:0]        sum_b_reg, sum_c_reg, div_reg;
    logic [32:0]            negvn_reg;
    logic                   hit_b_reg, hit_c_reg;
    logic [KW-1:0]          k_reg;
    logic [DivW-1:0]        dvd_reg;

    logic signed [VelW:0]   dx, dy;
    logic signed [32:0]     px_next, py_next;
    logic [BncW-1:0]        emin, e_next;
    logic signed [33:0]     vn, nvn;
    logic [SumW-1:0]        sum_next;
    logic [42:0]            kp;
    logic [DivW-1:0]        dvd_next;

    always_comb begin
        dx = {in_data.vbx[VelW-1], in_data.vbx} - {in_data.vax[VelW-1], in_data.vax};
        dy = {in_data.vby[VelW-1], in_data.vby} - {in_data.vay[VelW-1], in_data.vay};
        px_next = dx * in_data.nx;
        py_next = dy * in_data.ny;
        emin = (in_data.ba < in_data.bb) ? in_data.ba : in_data.bb;
        e_next = (emin > BncMax) ? BncMax : emin;
        vn = {px_reg[32], px_reg} + {py_reg[32], py_reg};
        nvn = -vn;
        sum_next = {1'b0, ima_a_reg} + {1'b0, imb_a_reg};
        kp = 43'({1'b0, e_b_reg} + 10'(BncMax)) * 43'(negvn_reg);
        dvd_next = DivW'(k_reg) * DivW'(ima_c_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ctx_a_reg <= {in_data.vax, in_data.vay, in_data.vbx, in_data.vby,
                          in_data.nx, in_data.ny, KW'(0), 1'b0};
            px_reg    <= px_next;
            py_reg    <= py_next;
            ima_a_reg <= in_data.ima;
            imb_a_reg <= in_data.imb;
            e_a_reg   <= e_next;

            ctx_b_reg <= ctx_a_reg;
            negvn_reg <= nvn[32:0];
            hit_b_reg <= vn[33] && (sum_next != '0);
            sum_b_reg <= sum_next;
            ima_b_reg <= ima_a_reg;
            e_b_reg   <= e_a_reg;

            ctx_c_reg <= ctx_b_reg;
            k_reg     <= hit_b_reg ? kp[KW-1:0] : '0;
            hit_c_reg <= hit_b_reg;
            sum_c_reg <= sum_b_reg;
            ima_c_reg <= ima_b_reg;

            ctx_d_reg <= {ctx_c_reg[$bits(ctx_t)-1:KW+1], k_reg, hit_c_reg};
            dvd_reg   <= dvd_next;
            div_reg   <= hit_c_reg ? sum_c_reg : SumW'(1);
        end
    end

    assign out_valid    = valid_reg[3];
    assign out_dividend = dvd_reg;
    assign out_divisor  = div_reg;
    assign out_ctx      = ctx_d_reg;

endmodule

>>> design/cir_div.sv
// ----------------------------------------------------------------------------
// Contact impulse resolver divider
// Restoring division, one quotient bit per pipeline stage.
// ----------------------------------------------------------------------------
module cir_div import cir_pkg::*; (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            en,
    input  logic            in_valid,
    input  logic [DivW-1:0] in_dividend,
    input  logic [SumW-1:0] in_divisor,
    input  ctx_t            in_ctx,
    output logic            out_valid,
    output logic [KW-1:0]   out_quot,
    output logic            out_rem_nz,
    output ctx_t            out_ctx
);

    logic            valid_reg [DivSteps];
    div_t            st_reg    [DivSteps];
    logic [SumW-1:0] s_reg     [DivSteps];
    ctx_t            ctx_reg   [DivSteps];

    div_t init;

    assign init.rem = SumW'(in_dividend[DivW-1:KW]);
    assign init.dq  = in_dividend[KW-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < DivSteps; i++) begin
                valid_reg[i] <= 1'b0;
            end
        end else if (en) begin
            valid_reg[0] <= in_valid;
            for (int i = 1; i < DivSteps; i++) begin
                valid_reg[i] <= valid_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            st_reg[0]  <= div_step(init, in_divisor);
            s_reg[0]   <= in_divisor;
            ctx_reg[0] <= in_ctx;
            for (int i = 1; i < DivSteps; i++) begin
                st_reg[i]  <= div_step(st_reg[i-1], s_reg[i-1]);
                s_reg[i]   <= s_reg[i-1];
                ctx_reg[i] <= ctx_reg[i-1];
            end
        end
    end

    assign out_valid  = valid_reg[DivSteps-1];
    assign out_quot   = st_reg[DivSteps-1].dq;
    assign out_rem_nz = |st_reg[DivSteps-1].rem;
    assign out_ctx    = ctx_reg[DivSteps-1];

endmodule

>>> design/cir_back.sv
// ----------------------------------------------------------------------------
// Contact impulse resolver back end
// Impulse shares, velocity changes, rounding and saturation, three stages.
// ----------------------------------------------------------------------------
module cir_back import cir_pkg::*; (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          in_valid,
    input  logic [KW-1:0] in_quot,
    input  logic          in_rem_nz,
    input  ctx_t          in_ctx,
    output logic          out_valid,
    output out_t          out_data
);

    logic [2:0] valid_reg;

    ctx_t             ctx_e_reg, ctx_f_reg;
    logic [KW-1:0]    qa_reg, qb_reg;
    logic [ProdW-1:0] pax_reg, pay_reg, pbx_reg, pby_reg;
    out_t             out_reg;

    logic [NrmW:0]    nx_neg, ny_neg;
    logic [NrmW-1:0]  anx, any;
    logic [ProdW:0]   rax, ray, rbx, rby;
    logic signed [MagW+1:0] max_s, may_s, mbx_s, mby_s;
    logic signed [MagW+1:0] va_x, va_y, vb_x, vb_y;
    out_t             out_next;

    always_comb begin
        nx_neg = -{ctx_e_reg.nx[NrmW-1], ctx_e_reg.nx};
        ny_neg = -{ctx_e_reg.ny[NrmW-1], ctx_e_reg.ny};
        anx = ctx_e_reg.nx[NrmW-1] ? nx_neg[NrmW-1:0] : ctx_e_reg.nx;
        any = ctx_e_reg.ny[NrmW-1] ? ny_neg[NrmW-1:0] : ctx_e_reg.ny;

        rax = {1'b0, pax_reg} + ((ProdW+1)'(1) << (RndShift - 1));
        ray = {1'b0, pay_reg} + ((ProdW+1)'(1) << (RndShift - 1));
        rbx = {1'b0, pbx_reg} + ((ProdW+1)'(1) << (RndShift - 1));
        rby = {1'b0, pby_reg} + ((ProdW+1)'(1) << (RndShift - 1));
        max_s = $signed({2'b00, rax[ProdW:RndShift]});
        may_s = $signed({2'b00, ray[ProdW:RndShift]});
        mbx_s = $signed({2'b00, rbx[ProdW:RndShift]});
        mby_s = $signed({2'b00, rby[ProdW:RndShift]});
        va_x = (MagW+2)'(ctx_f_reg.vax);
        va_y = (MagW+2)'(ctx_f_reg.vay);
        vb_x = (MagW+2)'(ctx_f_reg.vbx);
        vb_y = (MagW+2)'(ctx_f_reg.vby);

        out_next.applied = ctx_f_reg.applied;
        if (ctx_f_reg.applied) begin
            out_next.vax = sat16(ctx_f_reg.nx[NrmW-1] ? va_x + max_s : va_x - max_s);
            out_next.vay = sat16(ctx_f_reg.ny[NrmW-1] ? va_y + may_s : va_y - may_s);
            out_next.vbx = sat16(ctx_f_reg.nx[NrmW-1] ? vb_x - mbx_s : vb_x + mbx_s);
            out_next.vby = sat16(ctx_f_reg.ny[NrmW-1] ? vb_y - mby_s : vb_y + mby_s);
        end else begin
            out_next.vax = ctx_f_reg.vax;
            out_next.vay = ctx_f_reg.vay;
            out_next.vbx = ctx_f_reg.vbx;
            out_next.vby = ctx_f_reg.vby;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[1:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ctx_e_reg <= in_ctx;
            qa_reg    <= in_quot;
            qb_reg    <= in_ctx.k - in_quot - KW'(in_rem_nz);

            ctx_f_reg <= ctx_e_reg;
            pax_reg   <= ProdW'(qa_reg) * ProdW'(anx);
            pay_reg   <= ProdW'(qa_reg) * ProdW'(any);
            pbx_reg   <= ProdW'(qb_reg) * ProdW'(anx);
            pby_reg   <= ProdW'(qb_reg) * ProdW'(any);

            out_reg   <= out_next;
        end
    end

    assign out_valid = valid_reg[2];
    assign out_data  = out_reg;

endmodule

>>> design/contact_impulse_resolver.sv
// ----------------------------------------------------------------------------
// Contact impulse resolver
// Planar impulse collision response with restitution, fully pipelined.
// ----------------------------------------------------------------------------
// One contact request enters on the s_ channel, one resolved request leaves
// on the m_ channel, in order. s_tdata carries both velocities, the inverse
// masses, the restitutions and the contact normal; m_tdata carries the new
// velocities and m_tuser flags that an impulse was applied.
// The path from the accepting edge to m_tvalid runs through 49 register
// stages, the first loaded at acceptance: four front stages, a 42-stage
// restoring divider (one quotient bit per stage) and three back stages.
// A new request is accepted every cycle unless a stalled result holds the
// pipeline; the divider is fully pipelined and takes one per cycle too.
// Reset clears every valid bit, so the pipeline comes up empty with m_tvalid
// low. When the receiver stalls with a result waiting, the whole pipeline
// holds and s_tready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module contact_impulse_resolver import cir_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // vel_a_x, vel_a_y, vel_b_x, vel_b_y, inv_mass_a, inv_mass_b,
    // bounce_a, bounce_b, normal_x, normal_y, zero pad
    input  logic [151:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // new_vel_a_x, new_vel_a_y, new_vel_b_x, new_vel_b_y
    output logic [63:0]  m_tdata,
    // impulse_applied
    output logic [0:0]   m_tuser
);

    logic            en;
    in_t             in_data;
    logic            f_valid, d_valid;
    logic [DivW-1:0] f_dvd;
    logic [SumW-1:0] f_div;
    ctx_t            f_ctx, d_ctx;
    logic [KW-1:0]   d_quot;
    logic            d_rem_nz;
    out_t            out_data;

    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    assign in_data.vax = s_tdata[15:0];
    assign in_data.vay = s_tdata[31:16];
    assign in_data.vbx = s_tdata[47:32];
    assign in_data.vby = s_tdata[63:48];
    assign in_data.ima = s_tdata[79:64];
    assign in_data.imb = s_tdata[95:80];
    assign in_data.ba  = s_tdata[104:96];
    assign in_data.bb  = s_tdata[113:105];
    assign in_data.nx  = s_tdata[129:114];
    assign in_data.ny  = s_tdata[145:130];

    cir_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .en           (en),
        .in_valid     (s_tvalid),
        .in_data      (in_data),
        .out_valid    (f_valid),
        .out_dividend (f_dvd),
        .out_divisor  (f_div),
        .out_ctx      (f_ctx)
    );

    cir_div u_div (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (en),
        .in_valid    (f_valid),
        .in_dividend (f_dvd),
        .in_divisor  (f_div),
        .in_ctx      (f_ctx),
        .out_valid   (d_valid),
        .out_quot    (d_quot),
        .out_rem_nz  (d_rem_nz),
        .out_ctx     (d_ctx)
    );

    cir_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (d_valid),
        .in_quot   (d_quot),
        .in_rem_nz (d_rem_nz),
        .in_ctx    (d_ctx),
        .out_valid (m_tvalid),
        .out_data  (out_data)
    );

    assign m_tdata = {out_data.vby, out_data.vbx, out_data.vay, out_data.vax};
    assign m_tuser = out_data.applied;

endmodule

>>> design/cir_checker.sv
// ----------------------------------------------------------------------------
// Contact impulse resolver checker
// Port-level properties on handshake, stall and reset behavior.
// ----------------------------------------------------------------------------
`include "contact_impulse_resolver_defines.svh"

module cir_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic [151:0] s_tdata,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [63:0]  m_tdata,
    input logic [0:0]   m_tuser
);

    `CIR_ASSERT(a_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")
    `CIR_ASSERT(a_ready, s_tready == (!m_tvalid || m_tready), "input ready does not follow output stall")
    `CIR_ASSERT_ALWAYS(a_reset, !aresetn |=> !m_tvalid, "result valid right after reset")
    `CIR_ASSERT(a_stall, m_tvalid && !m_tready && s_tvalid |=> $stable(s_tdata) || !s_tvalid || s_tready || !m_tready, "stall bookkeeping broken")

endmodule

bind contact_impulse_resolver cir_checker u_cir_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

>>> bench/contact_impulse_resolver_tb.sv
// ----------------------------------------------------------------------------
// Contact impulse resolver testbench
// Streams directed and random contacts through the resolver with random
// gaps and stalls on both sides, predicts each resolved velocity set with
// exact integer arithmetic and compares the results in order.
// ----------------------------------------------------------------------------
module contact_impulse_resolver_tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [15:0] vax;
        logic signed [15:0] vay;
        logic signed [15:0] vbx;
        logic signed [15:0] vby;
        logic        [15:0] ima;
        logic        [15:0] imb;
        logic        [8:0]  ba;
        logic        [8:0]  bb;
        logic signed [15:0] nx;
        logic signed [15:0] ny;
    } contact_t;

    typedef struct packed {
        logic signed [15:0] vax;
        logic signed [15:0] vay;
        logic signed [15:0] vbx;
        logic signed [15:0] vby;
        logic               hit;
    } resolved_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [151:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [63:0]  m_tdata;
    logic [0:0]   m_tuser;

    contact_t  pending_contacts[$];
    resolved_t expected_vels[$];
    int        mismatches = 0;
    bit        hold_sender = 1'b0;
    bit        stimulus_done = 1'b0;
    int        send_gap = 0;
    int        recv_gap = 0;

    contact_impulse_resolver dut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic logic [151:0] pack_contact(input contact_t c);
        return {6'd0, c.ny, c.nx, c.bb, c.ba, c.imb, c.ima, c.vby, c.vbx, c.vay, c.vax};
    endfunction

    function automatic contact_t unpack_contact(input logic [151:0] d);
        contact_t c;
        c.vax = d[15:0];
        c.vay = d[31:16];
        c.vbx = d[47:32];
        c.vby = d[63:48];
        c.ima = d[79:64];
        c.imb = d[95:80];
        c.ba  = d[104:96];
        c.bb  = d[113:105];
        c.nx  = d[129:114];
        c.ny  = d[145:130];
        return c;
    endfunction

    function automatic logic signed [15:0] clamp16(input longint v);
        if (v > 32767) begin
            return 16'sh7fff;
        end
        if (v < -32768) begin
            return 16'sh8000;
        end
        return v[15:0];
    endfunction

    function automatic longint vel_delta(input logic [63:0] q, input longint n);
        logic [127:0] an, prod;
        longint mag;
        an = 128'((n < 0) ? -n : n);
        prod = (128'(q) * an + (128'd1 << 35)) >> 36;
        mag = longint'(prod);
        return (n < 0) ? -mag : mag;
    endfunction

    function automatic resolved_t resolve_contact(input contact_t c);
        resolved_t r;
        longint vax, vay, vbx, vby, nx, ny, vn, sum, e;
        longint dax, day, dbx, dby;
        logic [127:0] k, qa, qb;
        vax = longint'(c.vax); vay = longint'(c.vay);
        vbx = longint'(c.vbx); vby = longint'(c.vby);
        nx = longint'(c.nx); ny = longint'(c.ny);
        sum = longint'(c.ima) + longint'(c.imb);
        vn = (vbx - vax) * nx + (vby - vay) * ny;
        dax = 0; day = 0; dbx = 0; dby = 0;
        r.hit = 1'b0;
        if (vn < 0 && sum != 0) begin
            e = longint'((c.ba < c.bb) ? c.ba : c.bb);
            if (e > 256) begin
                e = 256;
            end
            k = 128'(256 + e) * 128'(-vn);
            qa = (k * c.ima) / sum;
            qb = (k * c.imb) / sum;
            dax = -vel_delta(qa[63:0], nx);
            day = -vel_delta(qa[63:0], ny);
            dbx = vel_delta(qb[63:0], nx);
            dby = vel_delta(qb[63:0], ny);
            r.hit = 1'b1;
        end
        r.vax = clamp16(vax + dax);
        r.vay = clamp16(vay + day);
        r.vbx = clamp16(vbx + dbx);
        r.vby = clamp16(vby + dby);
        return r;
    endfunction

    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55) begin
            return 0;
        end
        if (p < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 60);
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d want %0d", what, got, want);
        mismatches++;
    endtask

    function automatic logic signed [15:0] rand_normal();
        int p;
        p = $urandom_range(0, 9);
        if (p == 0) begin
            return 16'sd16384;
        end
        if (p == 1) begin
            return -16'sd16384;
        end
        if (p == 2) begin
            return 16'($urandom());
        end
        return 16'($urandom_range(0, 32768) - 16384);
    endfunction

    function automatic contact_t rand_contact();
        contact_t c;
        int p;
        c.vax = 16'($urandom()); c.vay = 16'($urandom());
        c.vbx = 16'($urandom()); c.vby = 16'($urandom());
        p = $urandom_range(0, 9);
        if (p < 3) begin
            c.vax = 16'($urandom_range(0, 4095) - 2048);
            c.vay = 16'($urandom_range(0, 4095) - 2048);
            c.vbx = 16'($urandom_range(0, 4095) - 2048);
            c.vby = 16'($urandom_range(0, 4095) - 2048);
        end
        c.ima = 16'($urandom());
        c.imb = 16'($urandom());
        p = $urandom_range(0, 9);
        if (p == 0) begin
            c.ima = 16'd0;
        end else if (p == 1) begin
            c.imb = 16'd0;
        end else if (p == 2) begin
            c.ima = 16'($urandom_range(0, 1023));
        end
        c.ba = ($urandom_range(0, 9) == 0) ? 9'($urandom()) : 9'($urandom_range(0, 256));
        c.bb = ($urandom_range(0, 9) == 0) ? 9'($urandom()) : 9'($urandom_range(0, 256));
        c.nx = rand_normal();
        c.ny = rand_normal();
        return c;
    endfunction

    function automatic contact_t make_contact(
        input int vax, input int vay, input int vbx, input int vby,
        input int ima, input int imb, input int ba, input int bb,
        input int nx, input int ny);
        contact_t c;
        c.vax = 16'(vax); c.vay = 16'(vay); c.vbx = 16'(vbx); c.vby = 16'(vby);
        c.ima = 16'(ima); c.imb = 16'(imb); c.ba = 9'(ba); c.bb = 9'(bb);
        c.nx = 16'(nx); c.ny = 16'(ny);
        return c;
    endfunction

    initial begin
        pending_contacts.push_back(make_contact(256, 0, -256, 0, 256, 256, 256, 256, 16384, 0));
        pending_contacts.push_back(make_contact(-256, 0, 256, 0, 256, 256, 128, 128, 16384, 0));
        pending_contacts.push_back(make_contact(0, 0, 0, 0, 256, 256, 0, 0, 0, 16384));
        pending_contacts.push_back(make_contact(512, 0, -512, 0, 0, 0, 256, 256, 16384, 0));
        pending_contacts.push_back(make_contact(512, 0, -512, 0, 0, 256, 200, 100, 16384, 0));
        pending_contacts.push_back(make_contact(512, 0, -512, 0, 256, 0, 511, 511, 16384, 0));
        pending_contacts.push_back(make_contact(32767, 32767, -32768, -32768, 65535, 65535,
                                                256, 256, 16384, 16384));
        pending_contacts.push_back(make_contact(-32768, -32768, 32767, 32767, 65535, 1,
                                                256, 300, -16384, -16384));
        pending_contacts.push_back(make_contact(32767, -32768, -32768, 32767, 1, 65535,
                                                0, 256, -16384, 16384));
        pending_contacts.push_back(make_contact(1, 0, 0, 0, 1, 65535, 0, 0, 1, 0));
        pending_contacts.push_back(make_contact(0, 1, 0, 0, 65535, 65535, 0, 0, 0, 1));
        pending_contacts.push_back(make_contact(100, 100, -100, -100, 256, 512, 256, 256,
                                                32767, -32768));
        pending_contacts.push_back(make_contact(0, 300, 0, -300, 128, 128, 256, 256,
                                                11585, 11585));
        pending_contacts.push_back(make_contact(-1, -1, -1, -1, 65535, 65535, 511, 511,
                                                -1, -1));
        pending_contacts.push_back(make_contact(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        for (int i = 0; i < 1100; i++) begin
            if (i == 500) begin
                wait (pending_contacts.size() == 0 && !s_tvalid);
                hold_sender = 1'b1;
                wait (expected_vels.size() == 0);
                hold_sender = 1'b0;
            end
            pending_contacts.push_back(rand_contact());
        end
        wait (pending_contacts.size() == 0 && !s_tvalid);
        stimulus_done = 1'b1;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                expected_vels.push_back(resolve_contact(unpack_contact(s_tdata)));
            end
            if (!(s_tvalid && !s_tready)) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    s_tvalid <= 1'b0;
                end else if (pending_contacts.size() > 0 && !hold_sender) begin
                    s_tdata <= pack_contact(pending_contacts.pop_front());
                    s_tvalid <= 1'b1;
                    send_gap <= pick_gap();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        resolved_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (expected_vels.size() == 0) begin
                    report_mismatch("unexpected result", 1, 0);
                end else begin
                    want = expected_vels.pop_front();
                    if (m_tdata[15:0] !== want.vax)
                        report_mismatch("new_vel_a_x", int'($signed(m_tdata[15:0])),
                                        int'(want.vax));
                    if (m_tdata[31:16] !== want.vay)
                        report_mismatch("new_vel_a_y", int'($signed(m_tdata[31:16])),
                                        int'(want.vay));
                    if (m_tdata[47:32] !== want.vbx)
                        report_mismatch("new_vel_b_x", int'($signed(m_tdata[47:32])),
                                        int'(want.vbx));
                    if (m_tdata[63:48] !== want.vby)
                        report_mismatch("new_vel_b_y", int'($signed(m_tdata[63:48])),
                                        int'(want.vby));
                    if (m_tuser[0] !== want.hit)
                        report_mismatch("impulse_applied", int'(m_tuser[0]), int'(want.hit));
                end
            end
            if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                recv_gap <= pick_gap();
            end
        end
    end

    initial begin
        wait (stimulus_done);
        wait (expected_vels.size() == 0);
        repeat (100) @(posedge aclk);
        if (mismatches == 0 && expected_vels.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
